// File: hw/rtl/wcc_pkg.sv
package wcc_pkg;

	localparam int MAX_WORDS   = 256;
	localparam int MAX_CELLS   = 64;
	localparam int COUNT_BITS  = 16;
	localparam int STORE_DEPTH = MAX_WORDS * MAX_CELLS;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
	localparam int STEP_BITS   = $clog2(MAX_CELLS + 1);
	localparam int WORDS_BITS  = 9;
	localparam int VALUE_BITS  = 24;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_READ  = 2'd2,
		OP_TOTAL = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_RANGE    = 2'd2,
		ST_INVALID  = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		CFG_HEIGHT = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_VOCAB  = 2'd2,
		CFG_LIMIT  = 2'd3
	} cfg_idx_e;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_ADD,
		S_READ,
		S_TOTAL,
		S_CLEAR
	} state_e;

	typedef struct packed {
		op_e        opcode;
		logic [7:0] word_index;
		logic [5:0] cell_flat;
		logic [2:0] cell_row;
		logic [2:0] cell_col;
	} item_t;

	typedef struct packed {
		status_e                 status;
		logic [VALUE_BITS-1:0]   result_value;
	} result_t;

	typedef struct packed {
		logic [3:0]  map_height;
		logic [3:0]  map_width;
		logic [8:0]  vocab_size;
		logic [15:0] count_limit;
	} cfg_t;

	typedef struct packed {
		op_e                   op;
		logic                  range_err;
		logic [ADDR_BITS-1:0]  addr;
		logic [STEP_BITS-1:0]  step;
		logic [WORDS_BITS-1:0] words;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
		logic deq;
	} back_stat_t;

endpackage

// File: hw/rtl/wcc_front.sv
module wcc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  wcc_pkg::item_t  item,
	input  logic            push,
	output logic            full,
	input  logic            q_full,
	input  logic            init_busy,
	output logic            q_push,
	output wcc_pkg::cmd_t   cmd,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output wcc_pkg::cfg_t   cfg
);
	import wcc_pkg::*;

	cfg_t                  cfg_q;
	logic [7:0]            cell_count;
	logic                  map_ok;
	logic [WORDS_BITS-1:0] words;
	logic                  word_ok;
	logic                  cell_ok;
	logic                  row_ok;
	logic                  col_ok;
	logic [ADDR_BITS-1:0]  flat_addr;
	logic [5:0]            total_cell;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_height  <= 4'd8;
			cfg_q.map_width   <= 4'd8;
			cfg_q.vocab_size  <= 9'd256;
			cfg_q.count_limit <= 16'hffff;
		end else if (cfg_valid) begin
			case (cfg_idx_e'(cfg_index))
				CFG_HEIGHT: cfg_q.map_height  <= cfg_data[3:0];
				CFG_WIDTH:  cfg_q.map_width   <= cfg_data[3:0];
				CFG_VOCAB:  cfg_q.vocab_size  <= cfg_data[8:0];
				CFG_LIMIT:  cfg_q.count_limit <= cfg_data;
				default:    cfg_q.count_limit <= cfg_q.count_limit;
			endcase
		end
	end

	// classify against the current map shape and vocabulary
	assign cell_count = 8'(cfg_q.map_height) * 8'(cfg_q.map_width);
	assign map_ok     = cell_count <= 8'(MAX_CELLS);
	assign words      = (cfg_q.vocab_size > WORDS_BITS'(MAX_WORDS)) ?
	                    WORDS_BITS'(MAX_WORDS) : cfg_q.vocab_size;
	assign word_ok    = {1'b0, item.word_index} < words;
	assign cell_ok    = {2'b00, item.cell_flat} < cell_count;
	assign row_ok     = {1'b0, item.cell_row} < cfg_q.map_height;
	assign col_ok     = {1'b0, item.cell_col} < cfg_q.map_width;
	assign flat_addr  = ADDR_BITS'(cell_count) * ADDR_BITS'(item.word_index) +
	                    ADDR_BITS'(item.cell_flat);
	assign total_cell = 6'(6'(item.cell_row) * 6'(cfg_q.map_width)) + 6'(item.cell_col);

	always_comb begin
		cmd.op    = item.opcode;
		cmd.step  = cell_count[STEP_BITS-1:0];
		cmd.words = words;
		if (item.opcode == OP_TOTAL) begin
			cmd.range_err = !map_ok || !row_ok || !col_ok;
			cmd.addr      = ADDR_BITS'(total_cell);
		end else begin
			cmd.range_err = !map_ok || !cell_ok || !word_ok;
			cmd.addr      = flat_addr;
		end
	end

	assign full   = q_full || init_busy;
	assign q_push = push && !full;

endmodule

// File: hw/rtl/wcc_queue.sv
module wcc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  wcc_pkg::cmd_t  wr_cmd,
	output logic           q_full,
	input  logic           rd,
	output logic           hd_valid,
	output wcc_pkg::cmd_t  hd
);
	import wcc_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign q_full   = cnt_q == 2'd2;
	assign hd_valid = cnt_q != 2'd0;
	assign hd       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wr_cmd;
	end

endmodule

// File: hw/rtl/wcc_back.sv
module wcc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hd_valid,
	input  wcc_pkg::cmd_t       hd,
	input  wcc_pkg::cfg_t       cfg,
	input  logic                pop,
	output logic                empty,
	output wcc_pkg::result_t    result,
	output wcc_pkg::back_stat_t stat
);
	import wcc_pkg::*;

	localparam logic [ADDR_BITS-1:0] SWEEP_LAST = ADDR_BITS'(STORE_DEPTH - 1);

	logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
	logic [COUNT_BITS-1:0] rd_q;

	state_e                state_q, state_d;
	logic                  valid_q, valid_d;
	logic                  res_valid_q;
	logic [ADDR_BITS-1:0]  sweep_q, sweep_d;
	logic                  rdv_s1;
	cmd_t                  cur_q;
	logic [ADDR_BITS-1:0]  taddr_q;
	logic [WORDS_BITS-1:0] issued_q;
	logic [VALUE_BITS-1:0] sum_q;
	result_t               res_q, res_d;

	logic                  pop_fire;
	logic                  deq;
	logic                  load;
	logic                  issue;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  raddr;
	logic                  we;
	logic [ADDR_BITS-1:0]  waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic                  res_we;
	logic [15:0]           thr;

	assign pop_fire = pop && res_valid_q;
	assign empty    = !res_valid_q;
	assign result   = res_q;
	assign thr      = (cfg.count_limit == 16'd0) ? 16'd0 : cfg.count_limit - 16'd1;

	assign stat.init_busy = state_q == S_INIT;
	assign stat.deq       = deq;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_q <= mem[raddr];
	end

	always_comb begin
		state_d             = state_q;
		valid_d             = valid_q;
		sweep_d             = sweep_q;
		deq                 = 1'b0;
		load                = 1'b0;
		issue               = 1'b0;
		rd_en               = 1'b0;
		raddr               = hd.addr;
		we                  = 1'b0;
		waddr               = sweep_q;
		wdata               = '0;
		res_we              = 1'b0;
		res_d.status        = ST_OK;
		res_d.result_value  = '0;
		case (state_q)
			S_INIT: begin
				we      = 1'b1;
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == SWEEP_LAST)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (hd_valid && (!res_valid_q || pop_fire)) begin
					deq  = 1'b1;
					load = 1'b1;
					if (hd.op == OP_CLEAR) begin
						state_d = S_CLEAR;
						sweep_d = '0;
					end else if (!valid_q) begin
						res_we       = 1'b1;
						res_d.status = ST_INVALID;
					end else if (hd.range_err) begin
						res_we       = 1'b1;
						res_d.status = ST_RANGE;
					end else begin
						case (hd.op)
							OP_ADD: begin
								rd_en   = 1'b1;
								state_d = S_ADD;
							end
							OP_READ: begin
								rd_en   = 1'b1;
								state_d = S_READ;
							end
							default: state_d = S_TOTAL;
						endcase
					end
				end
			end
			S_ADD: begin
				res_we  = 1'b1;
				waddr   = cur_q.addr;
				state_d = S_IDLE;
				if (rd_q >= thr) begin
					valid_d      = 1'b0;
					res_d.status = ST_OVERFLOW;
				end else begin
					we    = 1'b1;
					wdata = rd_q + 1'b1;
				end
			end
			S_READ: begin
				res_we             = 1'b1;
				res_d.result_value = VALUE_BITS'(rd_q);
				state_d            = S_IDLE;
			end
			S_TOTAL: begin
				// one read issued per cycle, each read's data summed in the cycle after
				if (issued_q < cur_q.words) begin
					rd_en = 1'b1;
					raddr = taddr_q;
					issue = 1'b1;
				end else if (!rdv_s1) begin
					res_we             = 1'b1;
					res_d.result_value = sum_q;
					state_d            = S_IDLE;
				end
			end
			S_CLEAR: begin
				we      = 1'b1;
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == SWEEP_LAST) begin
					valid_d = 1'b1;
					res_we  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			valid_q     <= 1'b1;
			sweep_q     <= '0;
			rdv_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			sweep_q <= sweep_d;
			rdv_s1  <= issue;
			if (res_we)
				res_valid_q <= 1'b1;
			else if (pop_fire)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q    <= hd;
			taddr_q  <= hd.addr;
			issued_q <= '0;
			sum_q    <= '0;
		end else begin
			if (issue) begin
				taddr_q  <= taddr_q + ADDR_BITS'(cur_q.step);
				issued_q <= issued_q + 1'b1;
			end
			if (rdv_s1)
				sum_q <= sum_q + VALUE_BITS'(rd_q);
		end
		if (res_we)
			res_q <= res_d;
	end

endmodule

// File: hw/rtl/word_cell_cooccurrence_counter_core.sv
// add and read: the count is read from the single count memory as the command is taken off
// the queue; the result, and for an add that does not overflow the write-back, follow before the next item is taken
// cell total: one memory read per word in use
// clear: one memory word zeroed per cycle
// after reset the count memory is swept to zero with full held high; configuration is at its
// reset values and the table is marked valid
module word_cell_cooccurrence_counter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  wcc_pkg::item_t    item,
	output logic              empty,
	input  logic              pop,
	output wcc_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import wcc_pkg::*;

	cfg_t       cfg;
	cmd_t       cmd;
	cmd_t       hd;
	logic       q_push;
	logic       q_full;
	logic       q_valid;
	back_stat_t stat;

	wcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.full      (full),
		.q_full    (q_full),
		.init_busy (stat.init_busy),
		.q_push    (q_push),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_cmd   (cmd),
		.q_full   (q_full),
		.rd       (stat.deq),
		.hd_valid (q_valid),
		.hd       (hd)
	);

	wcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.hd_valid (q_valid),
		.hd       (hd),
		.cfg      (cfg),
		.pop      (pop),
		.empty    (empty),
		.result   (result),
		.stat     (stat)
	);

	// a value only comes back with an ok status
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_OK |-> result.result_value == '0)
		else $error("nonzero result value with error status");

	a_deq_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		stat.deq |-> q_valid)
		else $error("command taken from empty queue");

	// nothing is taken in while the memory is being swept after reset
	a_no_beat_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init_busy |-> !q_push)
		else $error("beat accepted during reset sweep");

	a_first_result_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init_busy |=> empty)
		else $error("result produced during reset sweep");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import wcc_pkg::*;

	typedef struct {
		bit          is_reg;
		cfg_idx_e    sel;
		logic [15:0] data;
		item_t       it;
		bit          typed;
		result_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	item_t       item;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predictor state
	bit [COUNT_BITS-1:0] tally [STORE_DEPTH];
	bit                  table_ok   = 1'b1;
	int unsigned         rows_used  = 8;
	int unsigned         cols_used  = 8;
	int unsigned         vocab_used = 256;
	int unsigned         limit_reg  = 65535;

	result_t     due_results [$];
	int unsigned items_taken = 0;
	int unsigned faults      = 0;

	word_cell_cooccurrence_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic result_t tally_apply(item_t it);
		result_t         r;
		int unsigned     cells;
		int unsigned     words;
		int unsigned     addr;
		int unsigned     thr;
		int unsigned     c;
		int unsigned     w;
		longint unsigned sum;
		r.status       = ST_OK;
		r.result_value = '0;
		cells = rows_used * cols_used;
		words = (vocab_used > MAX_WORDS) ? MAX_WORDS : vocab_used;
		if (it.opcode == OP_CLEAR) begin
			foreach (tally[i]) tally[i] = '0;
			table_ok = 1'b1;
		end else if (!table_ok) begin
			r.status = ST_INVALID;
		end else if (it.opcode == OP_TOTAL) begin
			if (cells > MAX_CELLS || it.cell_row >= rows_used || it.cell_col >= cols_used) begin
				r.status = ST_RANGE;
			end else begin
				c   = it.cell_row * cols_used + it.cell_col;
				sum = 0;
				for (w = 0; w < words; w++) begin
					addr = cells * w + c;
					if (addr < STORE_DEPTH) sum += tally[addr];
				end
				r.result_value = (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
			end
		end else begin
			addr = cells * it.word_index + it.cell_flat;
			if (cells > MAX_CELLS || it.cell_flat >= cells || it.word_index >= words ||
					addr >= STORE_DEPTH) begin
				r.status = ST_RANGE;
			end else if (it.opcode == OP_READ) begin
				r.result_value = 24'(tally[addr]);
			end else begin
				thr = (limit_reg == 0) ? 0 : limit_reg - 1;
				if (thr > (1 << COUNT_BITS) - 1) thr = (1 << COUNT_BITS) - 1;
				if (tally[addr] >= thr) begin
					table_ok = 1'b0;
					r.status = ST_OVERFLOW;
				end else begin
					tally[addr] = tally[addr] + 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic bit calm_stretch();
		return items_taken >= 1400 && items_taken < 1700;
	endfunction

	function automatic int unsigned pick_below(int unsigned n, int unsigned span);
		if (n != 0 && $urandom_range(0, 99) < 85)
			return $urandom_range(0, ((n < span) ? n : span) - 1);
		return $urandom_range(0, span - 1);
	endfunction

	function automatic plan_row_t reg_row(cfg_idx_e sel, logic [15:0] data);
		plan_row_t p;
		p.is_reg = 1'b1;
		p.sel    = sel;
		p.data   = data;
		p.it     = '0;
		p.typed  = 1'b0;
		p.want   = '0;
		return p;
	endfunction

	function automatic plan_row_t op_row(op_e op, logic [7:0] w, logic [5:0] c, logic [2:0] r,
			logic [2:0] col, bit typed, status_e st, logic [23:0] val);
		plan_row_t p;
		p.is_reg            = 1'b0;
		p.sel               = CFG_HEIGHT;
		p.data              = '0;
		p.it.opcode         = op;
		p.it.word_index     = w;
		p.it.cell_flat      = c;
		p.it.cell_row       = r;
		p.it.cell_col       = col;
		p.typed             = typed;
		p.want.status       = st;
		p.want.result_value = val;
		return p;
	endfunction

	task automatic settle();
		push <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_e sel, logic [15:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (sel)
			CFG_HEIGHT: rows_used  = data[3:0];
			CFG_WIDTH:  cols_used  = data[3:0];
			CFG_VOCAB:  vocab_used = data[8:0];
			CFG_LIMIT:  limit_reg  = data;
			default:    limit_reg  = limit_reg;
		endcase
	endtask

	task automatic offer_item(item_t it, bit typed, result_t fixed);
		result_t predicted;
		if (!calm_stretch() && $urandom_range(0, 99) < 6) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		predicted = tally_apply(it);
		due_results.insert(due_results.size(), typed ? fixed : predicted);
		items_taken++;
	endtask

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		result_t want;
		bit      held;
		held = 1'b0;
		forever begin
			if (!held && items_taken >= 1000) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end
			pop <= calm_stretch() || ($urandom_range(0, 99) >= 6);
			@(posedge clk);
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d value %0d",
						$time, result.status, result.result_value);
					faults++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						faults++;
					end
					if (result.result_value !== want.result_value) begin
						$display("%0t: result_value expected %0d actual %0d",
							$time, want.result_value, result.result_value);
						faults++;
					end
				end
			end
		end
	end

	initial begin
		plan_row_t   plan [$];
		item_t       it;
		op_e         op;
		int unsigned h, w, v, lim, n, clears_left, roll, cells, words;
		logic [7:0]  last_word;
		logic [5:0]  last_cell;
		bit          have_last;
		logic [15:0] junk;

		arst_n    <= 1'b0;
		push      <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: 8x8 map, 256 words, limit 65535
		plan.insert(plan.size(), op_row(OP_READ,  0,   0,  0, 0, 1, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  0, 0, 1, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_ADD,   255, 63, 0, 0, 1, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_READ,  255, 63, 0, 0, 1, ST_OK, 1));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  7, 7, 1, ST_OK, 1));
		plan.insert(plan.size(), op_row(OP_ADD,   0,   0,  0, 0, 0, ST_OK, 0));
		// overflow bound of 2, then the table stays invalid until cleared
		plan.insert(plan.size(), reg_row(CFG_LIMIT, 16'd3));
		plan.insert(plan.size(), op_row(OP_ADD,   0,   0,  0, 0, 0, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_ADD,   0,   0,  0, 0, 1, ST_OVERFLOW, 0));
		plan.insert(plan.size(), op_row(OP_READ,  0,   0,  0, 0, 1, ST_INVALID, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  0, 0, 1, ST_INVALID, 0));
		plan.insert(plan.size(), op_row(OP_ADD,   1,   1,  0, 0, 1, ST_INVALID, 0));
		plan.insert(plan.size(), op_row(OP_CLEAR, 0,   0,  0, 0, 1, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_READ,  255, 63, 0, 0, 1, ST_OK, 0));
		// 3x5 map, 4 words: range edges
		plan.insert(plan.size(), reg_row(CFG_HEIGHT, 16'd3));
		plan.insert(plan.size(), reg_row(CFG_WIDTH, 16'd5));
		plan.insert(plan.size(), reg_row(CFG_VOCAB, 16'd4));
		plan.insert(plan.size(), op_row(OP_ADD,   3,   14, 0, 0, 0, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_ADD,   4,   0,  0, 0, 1, ST_RANGE, 0));
		plan.insert(plan.size(), op_row(OP_READ,  0,   15, 0, 0, 1, ST_RANGE, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  3, 0, 1, ST_RANGE, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  2, 5, 1, ST_RANGE, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  2, 4, 0, ST_OK, 0));
		// oversized map, upper data bits ignored
		plan.insert(plan.size(), reg_row(CFG_HEIGHT, 16'hA5F9));
		plan.insert(plan.size(), reg_row(CFG_WIDTH, 16'd8));
		plan.insert(plan.size(), reg_row(CFG_VOCAB, 16'd0));
		plan.insert(plan.size(), op_row(OP_READ,  0,   0,  0, 0, 1, ST_RANGE, 0));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  0, 0, 1, ST_RANGE, 0));
		// no words in use
		plan.insert(plan.size(), reg_row(CFG_HEIGHT, 16'd8));
		plan.insert(plan.size(), op_row(OP_TOTAL, 0,   0,  0, 0, 1, ST_OK, 0));
		plan.insert(plan.size(), op_row(OP_ADD,   0,   0,  0, 0, 1, ST_RANGE, 0));
		// vocabulary saturates, limit of zero rejects every add
		plan.insert(plan.size(), reg_row(CFG_VOCAB, 16'd300));
		plan.insert(plan.size(), reg_row(CFG_LIMIT, 16'd0));
		plan.insert(plan.size(), op_row(OP_ADD,   0,   0,  0, 0, 1, ST_OVERFLOW, 0));
		plan.insert(plan.size(), op_row(OP_CLEAR, 0,   0,  0, 0, 1, ST_OK, 0));

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].sel, plan[i].data);
			else
				offer_item(plan[i].it, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 8; ph++) begin
			clears_left = 2;
			if (ph == 0) begin
				h = 8;  w = 8;  v = 256; lim = 65535; n = 300;
			end else if (ph == 1) begin
				h = 1;  w = 1;  v = 1;   lim = 2;     n = 100; clears_left = 3;
			end else if (ph == 2) begin
				h = 15; w = 15; v = 511; lim = 1;     n = 40;
			end else if (ph == 3) begin
				h = 8;  w = 8;  v = 511; lim = 5;     n = 300;
			end else begin
				h   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
				w   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
				v   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
				lim = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(9, 65535);
				n   = 300;
			end
			junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
			write_reg(CFG_HEIGHT, 16'(h) | (junk & 16'hFFF0));
			write_reg(CFG_WIDTH,  16'(w) | (junk & 16'hFFF0));
			write_reg(CFG_VOCAB,  16'(v) | (junk & 16'hFE00));
			write_reg(CFG_LIMIT,  16'(lim));
			have_last = 1'b0;
			last_word = '0;
			last_cell = '0;
			repeat (n) begin
				cells = rows_used * cols_used;
				words = (vocab_used > MAX_WORDS) ? MAX_WORDS : vocab_used;
				roll  = $urandom_range(0, 99);
				if (clears_left != 0 &&
						((!table_ok && $urandom_range(0, 9) == 0) || $urandom_range(0, 199) == 0)) begin
					op = OP_CLEAR;
					clears_left--;
				end else if (roll < 50) begin
					op = OP_ADD;
				end else if (roll < 75) begin
					op = OP_READ;
				end else begin
					op = OP_TOTAL;
				end
				it.opcode   = op;
				it.cell_row = 3'(pick_below(rows_used, 8));
				it.cell_col = 3'(pick_below(cols_used, 8));
				// hammer a recent address so small limits overflow
				if (have_last && op != OP_TOTAL && $urandom_range(0, 99) < 30) begin
					it.word_index = last_word;
					it.cell_flat  = last_cell;
				end else begin
					it.word_index = 8'(pick_below(words, 256));
					it.cell_flat  = 6'(pick_below(cells, 64));
				end
				if (op == OP_ADD) begin
					have_last = 1'b1;
					last_word = it.word_index;
					last_cell = it.cell_flat;
				end
				offer_item(it, 1'b0, '0);
			end
		end

		push <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
